### rtl/mscc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscc_pkg: shared types and constants of the single-cycle mips core
// Instruction encodings, the execute result bundle and the register file
// reset values.
// ----------------------------------------------------------------------------
package mscc_pkg;

    typedef logic [31:0] t_word;
    typedef logic [4:0]  t_reg_idx;

    // kind of load that finishes in write-back
    typedef enum logic [1:0] {
        LD_NONE,
        LD_WORD,
        LD_BYTE,
        LD_HALF
    } t_ld_kind;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SW      = 6'h2b;

    // function codes of the special opcode
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2a;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    // fixed addresses and registers
    localparam t_word    PC_HALT     = 32'hffff_ffff;
    localparam t_word    SP_RESET    = 32'h0100_0000;
    localparam t_word    RA_RESET    = 32'hffff_ffff;
    localparam t_word    REGION_MASK = 32'hf000_0000;
    localparam t_reg_idx REG_SP      = 5'd29;
    localparam t_reg_idx REG_RA      = 5'd31;

    // what one instruction does, as seen after execute
    typedef struct packed {
        t_word     npc;
        logic      reg_wr;
        t_reg_idx  reg_idx;
        t_word     reg_val;
        t_ld_kind  ld_kind;
        logic      mem_wr;
        logic [29:0] mem_word;
        t_word     mem_val;
    } t_exec;

    // register contents right after reset
    function automatic t_word rf_reset_value(input t_reg_idx idx);
        t_word val;
        case (idx)
            REG_SP:  val = SP_RESET;
            REG_RA:  val = RA_RESET;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

### rtl/mscc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscc_in_if: instruction channel
// Valid/ready channel that carries one fetched instruction word.
// ----------------------------------------------------------------------------
interface mscc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr;

    modport source (output valid, output instr, input ready);
    modport sink   (input valid, input instr, output ready);
endinterface

### rtl/mscc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscc_out_if: result channel
// Valid/ready channel that carries the next pc, write-backs and halt flag.
// ----------------------------------------------------------------------------
interface mscc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [11:0] mem_index;
    logic [31:0] mem_value;
    logic        halted;

    modport source (
        output valid, output next_pc, output reg_write, output reg_index,
        output reg_value, output mem_write, output mem_index, output mem_value,
        output halted, input ready
    );
    modport sink (
        input valid, input next_pc, input reg_write, input reg_index,
        input reg_value, input mem_write, input mem_index, input mem_value,
        input halted, output ready
    );
endinterface

### rtl/mscc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscc_ram: generic simple dual-port ram
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module mscc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mscc_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscc_alu: execute stage
// Decodes one instruction and works out the next pc, register result,
// load kind and store request from the operand values.
// ----------------------------------------------------------------------------
module mscc_alu (
    input  mscc_pkg::t_word i_instr,
    input  mscc_pkg::t_word i_pc,
    input  mscc_pkg::t_word i_rs_val,
    input  mscc_pkg::t_word i_rt_val,
    output mscc_pkg::t_exec o_exec
);
    import mscc_pkg::*;

    logic [5:0] w_op;
    logic [5:0] w_fn;
    logic [4:0] w_sh;
    t_reg_idx   w_rt;
    t_reg_idx   w_rd;
    t_word      w_zimm;
    t_word      w_simm;
    t_word      w_seq;
    t_word      w_jtarget;
    t_word      w_btarget;
    t_word      w_addr;

    // field split
    assign w_op      = i_instr[31:26];
    assign w_fn      = i_instr[5:0];
    assign w_sh      = i_instr[10:6];
    assign w_rt      = i_instr[20:16];
    assign w_rd      = i_instr[15:11];
    assign w_zimm    = {16'b0, i_instr[15:0]};
    assign w_simm    = {{16{i_instr[15]}}, i_instr[15:0]};
    assign w_seq     = i_pc + 32'd4;
    assign w_jtarget = {w_seq[31:28], i_instr[25:0], 2'b00};
    assign w_btarget = w_seq + {w_simm[29:0], 2'b00};
    assign w_addr    = i_rs_val + w_simm;

    // decode and execute
    always_comb begin
        t_exec ex;
        ex          = '0;
        ex.npc      = w_seq;
        ex.ld_kind  = LD_NONE;
        ex.mem_word = w_addr[31:2];
        case (w_op)
            OP_SPECIAL: begin
                ex.reg_wr  = 1'b1;
                ex.reg_idx = w_rd;
                case (w_fn)
                    FN_ADD, FN_ADDU: ex.reg_val = i_rs_val + i_rt_val;
                    FN_SUB, FN_SUBU: ex.reg_val = i_rs_val - i_rt_val;
                    FN_AND:  ex.reg_val = i_rs_val & i_rt_val;
                    FN_OR:   ex.reg_val = i_rs_val | i_rt_val;
                    FN_NOR:  ex.reg_val = ~(i_rs_val | i_rt_val);
                    FN_SLT:  ex.reg_val = {31'b0, $signed(i_rs_val) < $signed(i_rt_val)};
                    FN_SLTU: ex.reg_val = {31'b0, i_rs_val < i_rt_val};
                    FN_SLL:  ex.reg_val = i_rt_val << w_sh;
                    FN_SRL:  ex.reg_val = i_rt_val >> w_sh;
                    FN_JR: begin
                        ex.reg_wr = 1'b0;
                        ex.npc    = i_rs_val;
                    end
                    default: ex.reg_wr = 1'b0;
                endcase
            end
            OP_ADDI, OP_ADDIU: begin
                ex.reg_wr  = 1'b1;
                ex.reg_idx = w_rt;
                ex.reg_val = w_addr;
            end
            OP_SLTI: begin
                ex.reg_wr  = 1'b1;
                ex.reg_idx = w_rt;
                ex.reg_val = {31'b0, $signed(i_rs_val) < $signed(w_simm)};
            end
            OP_SLTIU: begin
                ex.reg_wr  = 1'b1;
                ex.reg_idx = w_rt;
                ex.reg_val = {31'b0, i_rs_val < w_simm};
            end
            OP_ANDI: begin
                ex.reg_wr  = 1'b1;
                ex.reg_idx = w_rt;
                ex.reg_val = i_rs_val & w_zimm;
            end
            OP_ORI: begin
                ex.reg_wr  = 1'b1;
                ex.reg_idx = w_rt;
                ex.reg_val = i_rs_val | w_zimm;
            end
            OP_LUI: begin
                ex.reg_wr  = 1'b1;
                ex.reg_idx = w_rt;
                ex.reg_val = {i_instr[15:0], 16'b0};
            end
            OP_LW, OP_LBU, OP_LHU: begin
                ex.reg_wr  = 1'b1;
                ex.reg_idx = w_rt;
                case (w_op)
                    OP_LBU:  ex.ld_kind = LD_BYTE;
                    OP_LHU:  ex.ld_kind = LD_HALF;
                    default: ex.ld_kind = LD_WORD;
                endcase
            end
            OP_SW: begin
                ex.mem_wr  = 1'b1;
                ex.mem_val = i_rt_val;
            end
            OP_BEQ: begin
                if (i_rs_val == i_rt_val) begin
                    ex.npc = w_btarget;
                end
            end
            OP_BNE: begin
                if (i_rs_val != i_rt_val) begin
                    ex.npc = w_btarget;
                end
            end
            OP_J: ex.npc = w_jtarget;
            OP_JAL: begin
                ex.npc     = w_jtarget;
                ex.reg_wr  = 1'b1;
                ex.reg_idx = REG_RA;
                ex.reg_val = w_seq;
            end
            default: ex.reg_wr = 1'b0;
        endcase

        // r0 is never written
        if (ex.reg_idx == '0) begin
            ex.reg_wr = 1'b0;
        end
        if (!ex.reg_wr) begin
            ex.reg_idx = '0;
            ex.reg_val = '0;
            ex.ld_kind = LD_NONE;
        end

        // once halted the instruction is ignored
        if (i_pc == PC_HALT) begin
            ex         = '0;
            ex.npc     = PC_HALT;
            ex.ld_kind = LD_NONE;
        end
        o_exec = ex;
    end

endmodule

### rtl/mips_single_cycle_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_single_cycle_core: mips32 subset core without delay slots
// Executes one instruction word per transaction and reports the next pc,
// the register and memory write-backs and the halt flag.
// ----------------------------------------------------------------------------
// Usage
//   i_in carries the instruction word fetched at the current pc; o_out
//   carries one result transaction per instruction, in order.
//   o_out.valid comes from the result register: the register file rams
//   are read at the input transaction, execute with forwarding and data
//   memory access run from the instruction register, and the result
//   register loads at the end of execute and also finishes loads.
//   Throughput is one instruction per cycle while o_out is not stalled; a
//   load may be followed at once by a user of its value, forwarded from
//   the data ram read port.
//   Register file: two 32x32 rams, one per source operand. Data memory: one
//   MEM_WORDS x 32 ram; MEM_WORDS must be a power of two, which is unchecked.
//   Register file entries that were never written read as their reset value
//   through a valid bit per entry, so there is no clearing pass.
//   Reset sets pc to zero, empties the pipeline and holds i_in.ready low;
//   data memory contents are undefined until stored.
//   When o_out is stalled the whole pipeline holds and i_in.ready drops;
//   the result register stays on o_out until taken.
// ----------------------------------------------------------------------------
module mips_single_cycle_core #(
    parameter int unsigned MEM_WORDS = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mscc_in_if.sink    i_in,
    mscc_out_if.source o_out
);
    import mscc_pkg::*;

    localparam int unsigned MEM_AW = $clog2(MEM_WORDS);

    // result stage contents
    typedef struct packed {
        t_word       npc;
        logic        reg_wr;
        t_reg_idx    reg_idx;
        t_word       reg_val;
        t_ld_kind    ld_kind;
        logic        mem_wr;
        logic [11:0] mem_idx;
        t_word       mem_val;
        logic        halted;
    } t_result;

    logic        w_adv;
    logic        r_v1;
    logic        r_v2;
    t_word       r_pc;
    t_word       r_instr1;
    t_result     r_s2;
    t_result     n_s2;
    logic        r_fwd_wr;
    t_reg_idx    r_fwd_idx;
    t_word       r_fwd_val;
    logic [31:0] r_rf_valid;

    t_reg_idx    w_rs;
    t_reg_idx    w_rt;
    t_word       w_rf_rd_a;
    t_word       w_rf_rd_b;
    t_word       w_rs_val;
    t_word       w_rt_val;
    t_word       w_s2_val;
    t_word       w_dm_rd;
    logic        w_wb_en;
    t_exec       w_exec;
    logic [29:0] w_word;

    // pipeline moves when the result register is free or being taken
    assign w_adv      = !r_v2 || o_out.ready;
    assign i_in.ready = w_adv && i_rst_n;

    // register write-back happens as the result leaves
    assign w_wb_en = w_adv && r_v2 && r_s2.reg_wr;

    // load data is finished in the result stage
    always_comb begin
        case (r_s2.ld_kind)
            LD_WORD: w_s2_val = w_dm_rd;
            LD_BYTE: w_s2_val = {24'b0, w_dm_rd[7:0]};
            LD_HALF: w_s2_val = {16'b0, w_dm_rd[15:0]};
            default: w_s2_val = r_s2.reg_val;
        endcase
    end

    // register file, one ram per source operand
    mscc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (w_wb_en),
        .i_waddr (r_s2.reg_idx),
        .i_wdata (w_s2_val),
        .i_re    (w_adv),
        .i_raddr (i_in.instr[25:21]),
        .o_rdata (w_rf_rd_a)
    );

    mscc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (w_wb_en),
        .i_waddr (r_s2.reg_idx),
        .i_wdata (w_s2_val),
        .i_re    (w_adv),
        .i_raddr (i_in.instr[20:16]),
        .o_rdata (w_rf_rd_b)
    );

    // operand select: result stage, write at read time, ram, reset value
    assign w_rs = r_instr1[25:21];
    assign w_rt = r_instr1[20:16];

    always_comb begin
        if (r_v2 && r_s2.reg_wr && r_s2.reg_idx == w_rs) begin
            w_rs_val = w_s2_val;
        end else if (r_fwd_wr && r_fwd_idx == w_rs) begin
            w_rs_val = r_fwd_val;
        end else if (r_rf_valid[w_rs]) begin
            w_rs_val = w_rf_rd_a;
        end else begin
            w_rs_val = rf_reset_value(w_rs);
        end
    end

    always_comb begin
        if (r_v2 && r_s2.reg_wr && r_s2.reg_idx == w_rt) begin
            w_rt_val = w_s2_val;
        end else if (r_fwd_wr && r_fwd_idx == w_rt) begin
            w_rt_val = r_fwd_val;
        end else if (r_rf_valid[w_rt]) begin
            w_rt_val = w_rf_rd_b;
        end else begin
            w_rt_val = rf_reset_value(w_rt);
        end
    end

    // execute
    mscc_alu u_alu (
        .i_instr  (r_instr1),
        .i_pc     (r_pc),
        .i_rs_val (w_rs_val),
        .i_rt_val (w_rt_val),
        .o_exec   (w_exec)
    );

    // word index wraps at the memory depth
    assign w_word = w_exec.mem_word & 30'(MEM_WORDS - 1);

    // data memory, store and load issued from execute
    mscc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (w_adv && r_v1 && w_exec.mem_wr),
        .i_waddr (w_word[MEM_AW-1:0]),
        .i_wdata (w_exec.mem_val),
        .i_re    (w_adv && r_v1 && (w_exec.ld_kind != LD_NONE)),
        .i_raddr (w_word[MEM_AW-1:0]),
        .o_rdata (w_dm_rd)
    );

    // next result stage contents
    always_comb begin
        n_s2         = '0;
        n_s2.npc     = w_exec.npc;
        n_s2.reg_wr  = w_exec.reg_wr;
        n_s2.reg_idx = w_exec.reg_idx;
        n_s2.reg_val = w_exec.reg_val;
        n_s2.ld_kind = w_exec.ld_kind;
        n_s2.mem_wr  = w_exec.mem_wr;
        n_s2.halted  = (w_exec.npc == PC_HALT);
        if (w_exec.mem_wr) begin
            n_s2.mem_idx = w_word[11:0];
            n_s2.mem_val = w_exec.mem_val;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_pc       <= '0;
            r_fwd_wr   <= 1'b0;
            r_rf_valid <= '0;
        end else if (w_adv) begin
            r_v1     <= i_in.valid;
            r_v2     <= r_v1;
            r_fwd_wr <= w_wb_en;
            if (r_v1) begin
                r_pc <= w_exec.npc;
            end
            if (w_wb_en) begin
                r_rf_valid[r_s2.reg_idx] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_instr1  <= i_in.instr;
            r_s2      <= n_s2;
            r_fwd_idx <= r_s2.reg_idx;
            r_fwd_val <= w_s2_val;
        end
    end

    // result channel
    assign o_out.valid     = r_v2;
    assign o_out.next_pc   = r_s2.npc;
    assign o_out.reg_write = r_s2.reg_wr;
    assign o_out.reg_index = r_s2.reg_idx;
    assign o_out.reg_value = w_s2_val;
    assign o_out.mem_write = r_s2.mem_wr;
    assign o_out.mem_index = r_s2.mem_idx;
    assign o_out.mem_value = r_s2.mem_val;
    assign o_out.halted    = r_s2.halted;

endmodule

### tb/sv/mscc_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscc_check_pkg: result checking for the single-cycle mips core
// Architectural predictor of the core (pc, register file, data memory) and an
// in-order scoreboard of the retire transactions it expects.
// ----------------------------------------------------------------------------
package mscc_check_pkg;
    import mscc_pkg::*;

    localparam int unsigned MEM_WORDS    = 4096;
    localparam int unsigned MEM_AW       = 12;
    localparam int unsigned REPORT_LIMIT = 10;

    // opcodes the core executes as no-ops
    localparam logic [5:0] OP_SB = 6'h28;
    localparam logic [5:0] OP_SH = 6'h29;
    localparam logic [5:0] OP_LL = 6'h30;
    localparam logic [5:0] OP_SC = 6'h38;

    // one retire transaction of the core
    typedef struct packed {
        t_word       next_pc;
        logic        reg_write;
        t_reg_idx    reg_index;
        t_word       reg_value;
        logic        mem_write;
        logic [11:0] mem_index;
        t_word       mem_value;
        logic        halted;
    } t_retire;

    // instruction encoders
    function automatic t_word enc_r(logic [5:0] fn, t_reg_idx rs, t_reg_idx rt,
                                    t_reg_idx rd, logic [4:0] sh);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic t_word enc_i(logic [5:0] op, t_reg_idx rs, t_reg_idx rt,
                                    logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic t_word enc_j(logic [5:0] op, logic [25:0] tgt);
        return {op, tgt};
    endfunction

    class retire_scoreboard;
        t_word       pc;
        t_word       regs [32];
        t_word       mem [MEM_WORDS];
        bit          mem_valid [MEM_WORDS];
        int unsigned stored_words [$];
        t_retire     retire_q [$];
        t_word       instr_q [$];
        bit          unwritten_read;
        int unsigned errors;
        int unsigned reports;
        int unsigned n_items;
        int unsigned n_checked;
        int unsigned n_loads;
        int unsigned n_stores;
        int unsigned n_redirects;
        int unsigned n_reg_writes;

        function new();
            pc = '0;
            for (int i = 0; i < 32; i++) regs[i] = '0;
            regs[REG_SP] = SP_RESET;
            regs[REG_RA] = RA_RESET;
            for (int i = 0; i < MEM_WORDS; i++) begin
                mem[i]       = '0;
                mem_valid[i] = 1'b0;
            end
            errors       = 0;
            reports      = 0;
            n_items      = 0;
            n_checked    = 0;
            n_loads      = 0;
            n_stores     = 0;
            n_redirects  = 0;
            n_reg_writes = 0;
        endfunction

        // architectural step; state only changes when commit is set
        function t_retire execute_instr(t_word w, bit commit);
            logic [5:0]        op, fn;
            t_reg_idx          rs, rt, rd, widx;
            logic [4:0]        sh;
            t_word             simm, zimm, a, b, seq, npc, addr, wval, mval, word;
            logic              wr, mw;
            logic [MEM_AW-1:0] slot, midx;
            t_retire           r;
            r = '0;
            unwritten_read = 1'b0;
            // once halted every instruction is dropped
            if (pc == PC_HALT) begin
                r.next_pc = PC_HALT;
                r.halted  = 1'b1;
                return r;
            end
            op   = w[31:26];
            rs   = w[25:21];
            rt   = w[20:16];
            rd   = w[15:11];
            sh   = w[10:6];
            fn   = w[5:0];
            zimm = {16'h0000, w[15:0]};
            simm = {{16{w[15]}}, w[15:0]};
            a    = regs[rs];
            b    = regs[rt];
            seq  = pc + 32'd4;
            npc  = seq;
            addr = a + simm;
            slot = addr[MEM_AW+1:2];
            word = mem[slot];
            wr   = 1'b0;
            mw   = 1'b0;
            widx = '0;
            wval = '0;
            midx = '0;
            mval = '0;
            case (op)
                OP_SPECIAL: begin
                    wr   = 1'b1;
                    widx = rd;
                    case (fn)
                        FN_ADD, FN_ADDU: wval = a + b;
                        FN_SUB, FN_SUBU: wval = a - b;
                        FN_AND:  wval = a & b;
                        FN_OR:   wval = a | b;
                        FN_NOR:  wval = ~(a | b);
                        FN_SLT:  wval = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                        FN_SLTU: wval = (a < b) ? 32'd1 : 32'd0;
                        FN_SLL:  wval = b << sh;
                        FN_SRL:  wval = b >> sh;
                        FN_JR: begin
                            wr  = 1'b0;
                            npc = a;
                        end
                        default: wr = 1'b0;
                    endcase
                end
                OP_ADDI, OP_ADDIU: begin
                    wr = 1'b1; widx = rt; wval = a + simm;
                end
                OP_SLTI: begin
                    wr = 1'b1; widx = rt;
                    wval = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
                end
                OP_SLTIU: begin
                    wr = 1'b1; widx = rt; wval = (a < simm) ? 32'd1 : 32'd0;
                end
                OP_ANDI: begin
                    wr = 1'b1; widx = rt; wval = a & zimm;
                end
                OP_ORI: begin
                    wr = 1'b1; widx = rt; wval = a | zimm;
                end
                OP_LUI: begin
                    wr = 1'b1; widx = rt; wval = {w[15:0], 16'h0000};
                end
                OP_LW, OP_LBU, OP_LHU: begin
                    // byte and half loads keep the low bits of the whole word
                    wr = 1'b1;
                    widx = rt;
                    unwritten_read = !mem_valid[slot];
                    case (op)
                        OP_LBU:  wval = word & 32'h0000_00ff;
                        OP_LHU:  wval = word & 32'h0000_ffff;
                        default: wval = word;
                    endcase
                    if (commit) n_loads++;
                end
                OP_SW: begin
                    mw = 1'b1; midx = slot; mval = b;
                end
                OP_BEQ: begin
                    if (a == b) npc = seq + (simm << 2);
                end
                OP_BNE: begin
                    if (a != b) npc = seq + (simm << 2);
                end
                OP_J: begin
                    npc = {seq[31:28], w[25:0], 2'b00};
                end
                OP_JAL: begin
                    npc  = {seq[31:28], w[25:0], 2'b00};
                    wr   = 1'b1;
                    widx = REG_RA;
                    wval = seq;
                end
                default: ;
            endcase
            // r0 is hard-wired to zero
            if (wr && widx == '0) wr = 1'b0;
            if (!wr) begin
                widx = '0;
                wval = '0;
            end
            if (commit) begin
                if (wr) begin
                    regs[widx] = wval;
                    n_reg_writes++;
                end
                if (mw) begin
                    if (!mem_valid[midx]) begin
                        mem_valid[midx] = 1'b1;
                        stored_words.push_back(midx);
                    end
                    mem[midx] = mval;
                    n_stores++;
                end
                if (npc != seq) n_redirects++;
                pc = npc;
            end
            r.next_pc   = npc;
            r.reg_write = wr;
            r.reg_index = widx;
            r.reg_value = wval;
            r.mem_write = mw;
            r.mem_index = midx;
            r.mem_value = mval;
            r.halted    = (npc == PC_HALT);
            return r;
        endfunction

        // legal to issue: reads no unwritten word and does not halt
        function bit can_issue(t_word w);
            t_retire r;
            r = execute_instr(w, 1'b0);
            return !unwritten_read && !r.halted;
        endfunction

        function void note_input(t_word w);
            retire_q.push_back(execute_instr(w, 1'b1));
            instr_q.push_back(w);
            n_items++;
        endfunction

        function void compare_field(string name, t_word instr, t_word want, t_word got);
            if (want !== got) begin
                errors++;
                if (reports < REPORT_LIMIT)
                    $display("mismatch on %s for instr %h: expected %h, got %h",
                             name, instr, want, got);
                reports++;
            end
        endfunction

        function void check_result(t_retire got);
            t_retire want;
            t_word   instr;
            if (retire_q.size() == 0) begin
                errors++;
                if (reports < REPORT_LIMIT)
                    $display("unexpected result transaction: next_pc %h", got.next_pc);
                reports++;
                return;
            end
            want  = retire_q.pop_front();
            instr = instr_q.pop_front();
            n_checked++;
            compare_field("next_pc", instr, want.next_pc, got.next_pc);
            compare_field("reg_write", instr, want.reg_write, got.reg_write);
            compare_field("reg_index", instr, want.reg_index, got.reg_index);
            compare_field("reg_value", instr, want.reg_value, got.reg_value);
            compare_field("mem_write", instr, want.mem_write, got.mem_write);
            compare_field("mem_index", instr, want.mem_index, got.mem_index);
            compare_field("mem_value", instr, want.mem_value, got.mem_value);
            compare_field("halted", instr, want.halted, got.halted);
        endfunction
    endclass

endpackage

### tb/sv/mips_single_cycle_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_single_cycle_core_test: self-checking bench of the single-cycle core
// Drives a directed program and then random, memory-safe instruction streams
// with random gaps and stalls on both channels, and checks every retire
// transaction in order against an architectural predictor.
// ----------------------------------------------------------------------------
module mips_single_cycle_core_test;
    import mscc_pkg::*;
    import mscc_check_pkg::*;

    localparam int unsigned RESET_CYCLES   = 6;
    localparam int unsigned RANDOM_ITEMS   = 1200;
    localparam int unsigned HOLD_CYCLES    = 96;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mscc_in_if  instr_ch ();
    mscc_out_if result_ch ();

    retire_scoreboard sb;
    bit               hold_request = 1'b0;
    int unsigned      stall_cycles = 0;

    mips_single_cycle_core #(
        .MEM_WORDS(MEM_WORDS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (instr_ch.sink),
        .o_out  (result_ch.source)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // idle length: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // registers biased to a small set so values get reused
    function automatic t_reg_idx pick_reg();
        if ($urandom_range(0, 9) < 6) return t_reg_idx'($urandom_range(0, 7));
        return t_reg_idx'($urandom_range(0, 31));
    endfunction

    function automatic logic [5:0] pick_alu_funct();
        case ($urandom_range(0, 10))
            0:       return FN_ADD;
            1:       return FN_ADDU;
            2:       return FN_SUB;
            3:       return FN_SUBU;
            4:       return FN_AND;
            5:       return FN_OR;
            6:       return FN_NOR;
            7:       return FN_SLT;
            8:       return FN_SLTU;
            9:       return FN_SLL;
            default: return FN_SRL;
        endcase
    endfunction

    function automatic logic [5:0] pick_imm_op();
        case ($urandom_range(0, 6))
            0:       return OP_ADDI;
            1:       return OP_ADDIU;
            2:       return OP_SLTI;
            3:       return OP_SLTIU;
            4:       return OP_ANDI;
            5:       return OP_ORI;
            default: return OP_LUI;
        endcase
    endfunction

    // random instruction mix, loads aimed at words already stored
    function automatic t_word random_instr();
        int unsigned kind;
        t_reg_idx    rs, rt;
        logic [11:0] slot;
        t_word       target;
        logic [13:0] diff;
        logic [5:0]  op;
        logic [15:0] imm;
        kind = $urandom_range(0, 99);
        rs   = pick_reg();
        rt   = pick_reg();
        if (kind < 10) return $urandom();
        if (kind < 25) return enc_r(pick_alu_funct(), rs, rt, pick_reg(), 5'($urandom()));
        if (kind < 40) return enc_i(pick_imm_op(), rs, rt, 16'($urandom()));
        if (kind < 55 && sb.stored_words.size() != 0) begin
            // offset chosen so that base plus offset lands on the stored word
            slot   = sb.stored_words[$urandom_range(0, sb.stored_words.size() - 1)];
            target = {18'($urandom()), slot, 2'($urandom())};
            diff   = target[13:0] - sb.regs[rs][13:0];
            case ($urandom_range(0, 2))
                0:       op = OP_LW;
                1:       op = OP_LBU;
                default: op = OP_LHU;
            endcase
            return enc_i(op, rs, rt, {2'($urandom()), diff});
        end
        if (kind < 67) return enc_i(OP_SW, rs, rt, 16'($urandom()));
        if (kind < 77) begin
            op = $urandom_range(0, 1) ? OP_BEQ : OP_BNE;
            if ($urandom_range(0, 1)) rt = rs;
            if ($urandom_range(0, 3) == 0) imm = 16'($urandom());
            else imm = {{8{1'($urandom())}}, 8'($urandom())};
            return enc_i(op, rs, rt, imm);
        end
        if (kind < 83) return enc_j($urandom_range(0, 1) ? OP_J : OP_JAL, 26'($urandom()));
        if (kind < 88) return {OP_SPECIAL, rs, 15'($urandom()), FN_JR};
        if (kind < 94) begin
            case ($urandom_range(0, 3))
                0:       op = OP_SB;
                1:       op = OP_SH;
                2:       op = OP_LL;
                default: op = OP_SC;
            endcase
            return {op, 26'($urandom())};
        end
        return {OP_SPECIAL, 20'($urandom()), 6'($urandom())};
    endfunction

    // offer one instruction and wait for its transaction
    task automatic send_instr(input t_word w);
        instr_ch.valid <= 1'b1;
        instr_ch.instr <= w;
        do @(posedge i_clk); while (!(instr_ch.valid && instr_ch.ready));
        sb.note_input(w);
    endtask

    task automatic idle_sender(input int unsigned cycles);
        if (cycles != 0) begin
            instr_ch.valid <= 1'b0;
            instr_ch.instr <= $urandom();
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic issue(input t_word w);
        send_instr(w);
        idle_sender(pick_gap());
    endtask

    // stop offering until every outstanding result has retired
    task automatic drain_results();
        instr_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.retire_q.size() != 0);
    endtask

    // directed program: operand extremes and every operation
    task automatic run_directed();
        issue(enc_i(OP_LUI, 5'd0, 5'd1, 16'hffff));
        issue(enc_i(OP_ORI, 5'd1, 5'd1, 16'hffff));
        issue(enc_i(OP_ADDIU, 5'd0, 5'd2, 16'h7fff));
        issue(enc_i(OP_ADDI, 5'd0, 5'd3, 16'h8000));
        issue(enc_r(FN_ADD, 5'd1, 5'd1, 5'd4, 5'd0));
        // write to r0 is dropped
        issue(enc_r(FN_ADDU, 5'd2, 5'd1, 5'd0, 5'd0));
        issue(enc_r(FN_SUB, 5'd3, 5'd2, 5'd5, 5'd0));
        issue(enc_r(FN_SUBU, 5'd0, 5'd1, 5'd6, 5'd0));
        issue(enc_r(FN_AND, 5'd1, 5'd2, 5'd7, 5'd0));
        issue(enc_r(FN_OR, 5'd3, 5'd2, 5'd8, 5'd0));
        issue(enc_r(FN_NOR, 5'd1, 5'd0, 5'd9, 5'd0));
        // signed versus unsigned compare of the same operands
        issue(enc_r(FN_SLT, 5'd3, 5'd2, 5'd10, 5'd0));
        issue(enc_r(FN_SLTU, 5'd3, 5'd2, 5'd11, 5'd0));
        issue(enc_r(FN_SLL, 5'd0, 5'd1, 5'd12, 5'd31));
        issue(enc_r(FN_SRL, 5'd0, 5'd1, 5'd13, 5'd31));
        issue(enc_i(OP_SLTI, 5'd1, 5'd14, 16'h0000));
        issue(enc_i(OP_SLTIU, 5'd0, 5'd15, 16'hffff));
        issue(enc_i(OP_ANDI, 5'd1, 5'd16, 16'hffff));
        // address below zero wraps to the last word
        issue(enc_i(OP_SW, 5'd0, 5'd1, 16'hfffc));
        issue(enc_i(OP_LW, 5'd0, 5'd17, 16'hfffc));
        issue(enc_i(OP_LBU, 5'd0, 5'd18, 16'hffff));
        issue(enc_i(OP_LHU, 5'd0, 5'd19, 16'hfffe));
        issue(enc_i(OP_BNE, 5'd0, 5'd0, 16'h7fff));
        issue(enc_i(OP_BEQ, 5'd1, 5'd1, 16'h8000));
        // jump region comes from pc+4, which wraps across zero here
        issue(enc_j(OP_J, 26'h3ff_ffff));
        issue(enc_j(OP_JAL, 26'h000_0000));
        issue(enc_r(FN_JR, 5'd2, 5'd0, 5'd0, 5'd0));
        issue(enc_i(OP_SB, 5'd29, 5'd1, 16'h0000));
        issue({6'h3f, 26'h155_5555});
    endtask

    // stimulus and end of run
    initial begin : stimulus
        t_word       w;
        int unsigned k;
        bit          steady;
        sb = new();
        instr_ch.valid <= 1'b0;
        instr_ch.instr <= '0;
        i_rst_n        <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        steady = 1'b0;
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 50 == 0) steady = ($urandom_range(0, 3) == 0);
            if (k == 500 || k == 900) hold_request = 1'b1;
            do w = random_instr(); while (!sb.can_issue(w));
            send_instr(w);
            if (k % 400 == 200) drain_results();
            else if (!steady) idle_sender(pick_gap());
        end
        // halt through jr to all ones, then instructions that are ignored
        issue(enc_i(OP_ADDIU, 5'd0, 5'd1, 16'hffff));
        issue(enc_r(FN_JR, 5'd1, 5'd0, 5'd0, 5'd0));
        issue($urandom());
        send_instr($urandom());
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d instructions, %0d results checked", sb.n_items, sb.n_checked);
        $display("%0d register writes, %0d loads, %0d stores, %0d redirects, halt reached",
                 sb.n_reg_writes, sb.n_loads, sb.n_stores, sb.n_redirects);
        if (sb.errors == 0 && sb.retire_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // result side: random ready with bursts, long hold-off on request
    initial begin : result_sink
        int unsigned burst, gap;
        result_ch.ready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
                if ($urandom_range(0, 9) == 0) burst = $urandom_range(50, 150);
                else burst = $urandom_range(1, 12);
                repeat (burst) @(posedge i_clk);
                gap = pick_gap();
                if (gap != 0) begin
                    result_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // check each retire transaction
    always @(posedge i_clk) begin : result_monitor
        t_retire got;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got.next_pc   = result_ch.next_pc;
            got.reg_write = result_ch.reg_write;
            got.reg_index = result_ch.reg_index;
            got.reg_value = result_ch.reg_value;
            got.mem_write = result_ch.mem_write;
            got.mem_index = result_ch.mem_index;
            got.mem_value = result_ch.mem_value;
            got.halted    = result_ch.halted;
            sb.check_result(got);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (instr_ch.valid && instr_ch.ready)
                || (result_ch.valid && result_ch.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", stall_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
